[hdl/iafp_pkg.sv]
// Package for the integer ALU with factorial and primality test.
// Holds the command and response word types, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps

package iafp_pkg;

    localparam int FIELD_W   = 32;
    localparam int RESULT_W  = 64;
    localparam int FACT_LIMIT = 20;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_FACT  = 3'd4;
    localparam logic [2:0] OP_PRIME = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV0    = 2'd1;
    localparam logic [1:0] ST_OVF     = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [2:0]                kind;
        logic signed [FIELD_W-1:0] operand_a;
        logic signed [FIELD_W-1:0] operand_b;
    } t_cmd;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic [1:0]                 status;
        logic                       is_prime;
    } t_rsp;

endpackage

[hdl/iafp_div.sv]
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Shared by the divide operation and the trial-division primality loop.
// No package dependencies.
`timescale 1ns / 1ps

module iafp_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_dvs, n_dvs;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                n_rem = diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[hdl/integer_alu_factorial_primality.sv]
// Top level: integer ALU with factorial and trial-division primality test.
// Depends on iafp_pkg and iafp_div.
//
// One command word per start, one response word per command, shown for one cycle
// with o_done; the receiver cannot stall, and busy stays high while a divide,
// factorial or primality command runs. Add, subtract, multiply, invalid codes and
// flagged cases answer in the cycle after acceptance. Divide runs through the
// shared bit-serial divider and answers once the divider finishes. Factorial uses
// one 64 x 5 multiply per cycle and multiplies by 2 up to a in turn. Primality
// tries divisors d = 2, 3, ... while d*d <= a, each trial running through the
// shared divider, so a prime near 2^31 takes about 46k trials; a composite stops
// at its smallest factor.
`timescale 1ns / 1ps

module integer_alu_factorial_primality #(
    parameter int OPERAND_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  iafp_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_done,
    output iafp_pkg::t_rsp o_rsp
);

    import iafp_pkg::*;

    localparam int N = OPERAND_BITS;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV       = 3'd1;
    localparam logic [2:0] S_FACT      = 3'd2;
    localparam logic [2:0] S_PRIME_CHK = 3'd3;
    localparam logic [2:0] S_PRIME_DIV = 3'd4;

    logic [2:0]  r_state, n_state;
    logic        r_done, n_done;
    t_rsp        r_rsp, n_rsp;
    logic [63:0] r_acc, n_acc;
    logic [4:0]  r_i, n_i;
    logic [4:0]  r_lim, n_lim;
    logic        r_neg, n_neg;
    logic [N-1:0] r_n, n_n;
    logic [N-1:0] r_d, n_d;
    logic [N:0]   r_sq, n_sq;

    logic signed [N-1:0]   a_n, b_n;
    logic signed [63:0]    a_x, b_x;
    logic signed [2*N-1:0] mul_p;
    logic [N-1:0]          a_mag, b_mag;
    logic                  a_is_min;

    logic         div_start;
    logic [N-1:0] div_dvd, div_dvs;
    logic         div_done;
    logic [N-1:0] div_quo, div_rem;

    assign a_n      = i_cmd.operand_a[N-1:0];
    assign b_n      = i_cmd.operand_b[N-1:0];
    assign a_x      = 64'(a_n);
    assign b_x      = 64'(b_n);
    assign mul_p    = a_n * b_n;
    assign a_mag    = a_n[N-1] ? N'(-a_n) : a_n;
    assign b_mag    = b_n[N-1] ? N'(-b_n) : b_n;
    assign a_is_min = (a_n == {1'b1, {(N-1){1'b0}}});

    iafp_div #(
        .W(N)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        n_acc     = r_acc;
        n_i       = r_i;
        n_lim     = r_lim;
        n_neg     = r_neg;
        n_n       = r_n;
        n_d       = r_d;
        n_sq      = r_sq;
        div_start = 1'b0;
        div_dvd   = a_mag;
        div_dvs   = b_mag;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rsp.result   = '0;
                    n_rsp.status   = ST_OK;
                    n_rsp.is_prime = 1'b0;
                    case (i_cmd.kind)
                        OP_ADD: begin
                            n_rsp.result = a_x + b_x;
                            n_done       = 1'b1;
                        end
                        OP_SUB: begin
                            n_rsp.result = a_x - b_x;
                            n_done       = 1'b1;
                        end
                        OP_MUL: begin
                            n_rsp.result = 64'(mul_p);
                            n_done       = 1'b1;
                        end
                        OP_DIV: begin
                            if (b_n == '0) begin
                                n_rsp.status = ST_DIV0;
                                n_done       = 1'b1;
                            end else if (a_is_min && b_n == '1) begin
                                n_rsp.status = ST_OVF;
                                n_done       = 1'b1;
                            end else begin
                                div_start = 1'b1;
                                n_neg     = a_n[N-1] ^ b_n[N-1];
                                n_state   = S_DIV;
                            end
                        end
                        OP_FACT: begin
                            if (a_x > 64'(FACT_LIMIT)) begin
                                n_rsp.result = {1'b0, {63{1'b1}}};
                                n_rsp.status = ST_OVF;
                                n_done       = 1'b1;
                            end else if (a_x < 64'sd2) begin
                                n_rsp.result = 64'sd1;
                                n_done       = 1'b1;
                            end else begin
                                n_acc   = 64'd1;
                                n_i     = 5'd2;
                                n_lim   = a_n[4:0];
                                n_state = S_FACT;
                            end
                        end
                        OP_PRIME: begin
                            if (a_x < 64'sd2) begin
                                n_done = 1'b1;
                            end else begin
                                n_n     = a_n;
                                n_d     = N'(2);
                                n_sq    = (N+1)'(4);
                                n_state = S_PRIME_CHK;
                            end
                        end
                        default: begin
                            n_rsp.status = ST_INVALID;
                            n_done       = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_rsp.result = r_neg ? -64'(div_quo) : 64'(div_quo);
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FACT: begin
                n_acc = r_acc * 64'(r_i);
                if (r_i == r_lim) begin
                    n_rsp.result = n_acc;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_i = r_i + 5'd1;
                end
            end
            S_PRIME_CHK: begin
                div_dvd = r_n;
                div_dvs = r_d;
                if (r_sq > {1'b0, r_n}) begin
                    n_rsp.is_prime = 1'b1;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_PRIME_DIV;
                end
            end
            S_PRIME_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_d     = r_d + N'(1);
                        n_sq    = r_sq + {r_d, 1'b1};
                        n_state = S_PRIME_CHK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_rsp <= n_rsp;
        r_acc <= n_acc;
        r_i   <= n_i;
        r_lim <= n_lim;
        r_neg <= n_neg;
        r_n   <= n_n;
        r_d   <= n_d;
        r_sq  <= n_sq;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("response strobe while a command is still running");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted command neither answered nor running");

    a_div_done_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV || r_state == S_PRIME_DIV))
        else $error("divider finished with no waiting state");

    a_prime_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.is_prime) |-> (o_rsp.result == '0 && o_rsp.status == ST_OK))
        else $error("prime flag with nonzero result or status");

endmodule
